// ===== design/caf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_pkg
// Shared types and constants of the common ancestor finder.
// ----------------------------------------------------------------------------
package caf_pkg;

  localparam int NODE_W = 11;
  localparam int DEF_MAX_NODES = 1024;

  typedef logic [NODE_W-1:0] node_t;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // one classified item on its way from front to back
  typedef struct packed {
    logic  is_query;
    node_t a;
    node_t b;
  } item_t;

  // back to front status
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

endpackage

// ===== design/caf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_front
// Accepts input beats, screens loads and holds items in a two-entry queue.
// ----------------------------------------------------------------------------
module caf_front #(
  parameter int MAX_NODES = caf_pkg::DEF_MAX_NODES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               cmd,
  input  caf_pkg::node_t     first_node,
  input  caf_pkg::node_t     second_node,
  input  caf_pkg::back_stat_t stat,
  output caf_pkg::item_t     head,
  output logic               head_valid
);
  import caf_pkg::*;

  localparam logic [1:0] Q_FULL = 2'd2;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       accept;
  logic       keep;
  logic       in_range;
  item_t      item;

  assign full     = (count == Q_FULL) || stat.clearing;
  assign accept   = push && !full;
  assign in_range = (first_node != '0) && (32'(first_node) <= 32'(MAX_NODES));
  assign keep     = accept && ((cmd == CMD_QUERY) || in_range);

  always_comb begin
    item.is_query = (cmd == CMD_QUERY);
    item.a        = first_node;
    // a parent that is not smaller makes the node a root
    if (cmd == CMD_QUERY || second_node < first_node) begin
      item.b = second_node;
    end else begin
      item.b = '0;
    end
  end

  assign count_next = count + {1'b0, keep} - {1'b0, stat.pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (keep) begin
        wr_ptr <= ~wr_ptr;
      end
      if (stat.pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      q[wr_ptr] <= item;
    end
  end

  assign head       = q[rd_ptr];
  assign head_valid = (count != '0);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_FULL) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    stat.pop |-> count != '0) else $error("pop of empty queue");
  a_keep_room: assert property (@(posedge clk) disable iff (rst)
    keep |-> count != Q_FULL) else $error("push into full queue");

endmodule

// ===== design/caf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_back
// Parent table memory, clearing pass, ancestor walk and result register.
// ----------------------------------------------------------------------------
module caf_back #(
  parameter int MAX_NODES = caf_pkg::DEF_MAX_NODES
) (
  input  logic                clk,
  input  logic                rst,
  input  caf_pkg::item_t      head,
  input  logic                head_valid,
  output caf_pkg::back_stat_t stat,
  input  logic                pop,
  output logic                empty,
  output caf_pkg::node_t      meeting_node
);
  import caf_pkg::*;

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [AW-1:0] clr_cnt;
  node_t         wa;
  node_t         wa_next;
  node_t         wb;
  node_t         wb_next;
  logic          sel;
  logic          sel_next;
  node_t         result;
  node_t         result_next;
  logic          out_valid;
  logic          out_pop;
  logic          load_out;
  logic          q_pop;
  logic          first_big;
  node_t         larger;

  node_t         mem [MAX_NODES];
  node_t         rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  node_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  assign out_pop   = pop && out_valid;
  assign empty     = !out_valid;
  assign first_big = (wa > wb);
  assign larger    = first_big ? wa : wb;

  always_comb begin
    state_next  = state;
    wa_next     = wa;
    wb_next     = wb;
    sel_next    = sel;
    result_next = result;
    load_out    = 1'b0;
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = clr_cnt;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = AW'(larger - 1'b1);
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_valid) begin
          q_pop = 1'b1;
          if (head.is_query) begin
            wa_next    = head.a;
            wb_next    = head.b;
            state_next = ST_WALK;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = AW'(head.a - 1'b1);
            mem_wdata = head.b;
          end
        end
      end
      ST_WALK: begin
        if (wa == wb || wa == '0 || wb == '0) begin
          result_next = (wa == wb) ? wa : '0;
          state_next  = ST_DONE;
        end else if (32'(larger) > 32'(MAX_NODES)) begin
          // node without an entry reads as a root
          if (first_big) begin
            wa_next = '0;
          end else begin
            wb_next = '0;
          end
        end else begin
          mem_re     = 1'b1;
          sel_next   = !first_big;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (sel) begin
          wb_next = rdata;
        end else begin
          wa_next = rdata;
        end
        state_next = ST_WALK;
      end
      ST_DONE: begin
        if (!out_valid || out_pop) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wa     <= wa_next;
    wb     <= wb_next;
    sel    <= sel_next;
    result <= result_next;
    if (load_out) begin
      meeting_node <= result;
    end
  end

  // parent table
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  assign stat.pop      = q_pop;
  assign stat.clearing = (state == ST_CLEAR);

  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !q_pop) else $error("item taken during clear");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> head_valid) else $error("pop without queued item");
  a_read_after_walk: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> $past(state) == ST_WALK) else $error("read without walk step");
  a_parent_smaller: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> rdata < (sel ? wb : wa)) else $error("parent not below node");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE) else $error("result outside done");

endmodule

// ===== design/common_ancestor_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// common_ancestor_finder
// Parent table for a forest of numbered nodes with lowest common ancestor
// queries by a two-pointer walk toward the roots.
//
//   channel   handshake       payload
//   input     push / full     cmd, first_node, second_node
//   result    pop / empty     meeting_node
//
// An accepted load waits in the two-entry queue and reaches the table when
// the walk unit takes it while idle.
// A query takes at most about 2 * MAX_NODES table reads; a node above
// MAX_NODES drops to 0 without a read.
// After reset a clearing pass zeroes every table entry; full is high during it.
// A waiting result does not stop loads; a new result waits in the walk unit,
// which then takes no items until the waiting beat is popped.
// ----------------------------------------------------------------------------
module common_ancestor_finder #(
  parameter int MAX_NODES = caf_pkg::DEF_MAX_NODES
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic           cmd,
  input  caf_pkg::node_t first_node,
  input  caf_pkg::node_t second_node,
  output logic           empty,
  input  logic           pop,
  output caf_pkg::node_t meeting_node
);
  import caf_pkg::*;

  back_stat_t stat;
  item_t      head;
  logic       head_valid;

  caf_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .first_node (first_node),
    .second_node(second_node),
    .stat       (stat),
    .head       (head),
    .head_valid (head_valid)
  );

  caf_back #(
    .MAX_NODES(MAX_NODES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .stat        (stat),
    .pop         (pop),
    .empty       (empty),
    .meeting_node(meeting_node)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for common_ancestor_finder: a driver pushes load and
// query items from a pending queue, a local parent table predicts each
// lowest common ancestor at acceptance, and a monitor compares every popped
// beat against the oldest prediction. Sender and receiver idling vary by
// phase.
// ----------------------------------------------------------------------------
module testbench;

  import caf_pkg::*;

  localparam int MAX_NODES = DEF_MAX_NODES;
  localparam int NODE_MAX_CODE = (1 << NODE_W) - 1;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 90;

  typedef struct {
    logic  cmd;
    node_t a;
    node_t b;
  } stim_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  push = 1'b0;
  logic  cmd = CMD_LOAD;
  node_t first_node = '0;
  node_t second_node = '0;
  logic  pop = 1'b0;
  logic  full;
  logic  empty;
  node_t meeting_node;

  stim_t pending_items[$];
  node_t meet_expected[$];
  node_t parent_mem[1:MAX_NODES];

  int send_idle_pct = 32;
  int recv_idle_pct = 70;
  int useful_items = 0;
  int mismatches = 0;
  int loads_taken = 0;
  int queries_taken = 0;
  int beats_checked = 0;

  common_ancestor_finder #(.MAX_NODES(MAX_NODES)) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .cmd(cmd),
    .first_node(first_node),
    .second_node(second_node),
    .empty(empty),
    .pop(pop),
    .meeting_node(meeting_node)
  );

  always #6 clk = ~clk;

  function automatic node_t parent_lookup(node_t n);
    if (n == 0 || n > MAX_NODES) return '0;
    return parent_mem[n];
  endfunction

  // two-pointer walk: lift the larger node until they meet or one hits 0
  function automatic node_t ancestor_walk(node_t x, node_t y);
    node_t u;
    node_t v;
    u = x;
    v = y;
    while (u != v && u != 0 && v != 0) begin
      if (u > v) u = parent_lookup(u);
      else v = parent_lookup(v);
    end
    return (u == v) ? u : node_t'(0);
  endfunction

  task automatic note_mismatch(string what, node_t want, node_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  task automatic add_item(logic c, int a, int b);
    stim_t s;
    s.cmd = c;
    s.a = node_t'(a);
    s.b = node_t'(b);
    pending_items.push_back(s);
    if (c == CMD_QUERY || (s.a != 0 && s.a <= MAX_NODES)) useful_items++;
  endtask

  task automatic add_directed();
    add_item(CMD_LOAD, 1, 0);
    add_item(CMD_LOAD, 2, 1);
    add_item(CMD_LOAD, 3, 1);
    add_item(CMD_LOAD, 1024, 1023);
    add_item(CMD_LOAD, 1023, 2);
    add_item(CMD_LOAD, 7, 7);
    add_item(CMD_LOAD, 6, NODE_MAX_CODE);
    add_item(CMD_LOAD, 0, 1);
    add_item(CMD_LOAD, NODE_MAX_CODE, 5);
    add_item(CMD_LOAD, MAX_NODES + 1, 3);
    add_item(CMD_QUERY, 1024, 3);
    add_item(CMD_QUERY, 2, 3);
    add_item(CMD_QUERY, 1024, 1024);
    add_item(CMD_QUERY, 0, 5);
    add_item(CMD_QUERY, 5, 0);
    add_item(CMD_QUERY, 0, 0);
    add_item(CMD_QUERY, NODE_MAX_CODE, NODE_MAX_CODE);
    add_item(CMD_QUERY, NODE_MAX_CODE, 1);
    add_item(CMD_QUERY, 7, 1);
    add_item(CMD_QUERY, 6, 6);
    add_item(CMD_QUERY, 1, 1024);
    add_item(CMD_QUERY, MAX_NODES + 1, MAX_NODES + 1);
  endtask

  task automatic build_phase(input int want);
    int start;
    int kind;
    int lo;
    int hi;
    int n;
    int par;
    int len;
    int x;
    int y;
    start = useful_items;
    while (useful_items - start < want) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        // small random tree inside a window, then queries inside it
        hi = ($urandom_range(9) == 0) ? $urandom_range(64, MAX_NODES) : $urandom_range(8, 64);
        lo = (hi > 16) ? hi - $urandom_range(7, 15) : 1;
        repeat ($urandom_range(3, 6)) begin
          n = $urandom_range(lo, hi);
          if (n == 1 || $urandom_range(7) == 0) par = 0;
          else par = $urandom_range((n > 16) ? n - 16 : 0, n - 1);
          add_item(CMD_LOAD, n, par);
        end
        repeat ($urandom_range(2, 3)) begin
          x = $urandom_range(lo, hi);
          y = ($urandom_range(5) == 0) ? x : $urandom_range(lo, hi);
          add_item(CMD_QUERY, x, y);
        end
      end else if (kind < 70) begin
        // straight chain for a longer walk
        n = $urandom_range(2, MAX_NODES - 12);
        len = $urandom_range(3, 12);
        for (int i = 1; i <= len; i++) add_item(CMD_LOAD, n + i, n + i - 1);
        y = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_NODES) : n + $urandom_range(0, len);
        add_item(CMD_QUERY, n + len, y);
      end else if (kind < 80) begin
        // parent not smaller than node
        n = $urandom_range(1, MAX_NODES);
        add_item(CMD_LOAD, n, $urandom_range(n, NODE_MAX_CODE));
        if ($urandom_range(1)) add_item(CMD_QUERY, n, $urandom_range(1, MAX_NODES));
      end else begin
        add_item(1'($urandom_range(1)), $urandom_range(NODE_MAX_CODE),
                 $urandom_range(NODE_MAX_CODE));
      end
    end
  endtask

  // driver: predicts on acceptance, then offers the next pending item
  always @(posedge clk) begin : drive_p
    stim_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        if (cmd == CMD_QUERY) begin
          meet_expected.push_back(ancestor_walk(first_node, second_node));
          queries_taken++;
        end else begin
          if (first_node != 0 && first_node <= MAX_NODES)
            parent_mem[first_node] = (second_node < first_node) ? second_node : node_t'(0);
          loads_taken++;
        end
      end
      if (!push || !full) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          push <= 1'b1;
          cmd <= nxt.cmd;
          first_node <= nxt.a;
          second_node <= nxt.b;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: each popped beat against the oldest expected meeting node
  always @(posedge clk) begin : watch_p
    node_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (meet_expected.size() == 0) begin
          note_mismatch("unexpected beat", '0, meeting_node);
        end else begin
          want = meet_expected.pop_front();
          beats_checked++;
          if (meeting_node !== want) note_mismatch("meeting_node", want, meeting_node);
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    for (int i = 1; i <= MAX_NODES; i++) parent_mem[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 70;
          add_directed();
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      build_phase(PHASE_ITEMS);
      while (pending_items.size() != 0 || push) @(posedge clk);
    end
    while (meet_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d loads and %0d ancestor queries, %0d beats checked,",
             loads_taken, queries_taken, beats_checked);
    $display("across three sender/receiver idle patterns; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("common_ancestor_finder: match");
    end else begin
      $display("common_ancestor_finder: mismatch");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("timeout with %0d beats still expected", meet_expected.size());
    $display("common_ancestor_finder: mismatch");
    $finish;
  end

endmodule
